/* src/ftgd_pkg.sv */
// ----------------------------------------------------------------------------
// ftgd_pkg
// Shared types and constants of the flex/tilt gesture detector: register
// file layout and reset values, event codes, tilt directions and the word
// that goes from the detector core into the response queue.
// ----------------------------------------------------------------------------
package ftgd_pkg;

   // Register port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LEVEL_HIGH     = 3'd0,
      REG_LEVEL_LOW      = 3'd1,
      REG_DEBOUNCE       = 3'd2,
      REG_CLOSE_HOLD     = 3'd3,
      REG_OPEN_AFTER     = 3'd4,
      REG_REPORT_WINDOW  = 3'd5,
      REG_TILT_PERIOD    = 3'd6,
      REG_TILT_THRESHOLD = 3'd7
   } csr_index_type;

   // Register file contents
   typedef struct packed {
      logic [9:0]  level_high;
      logic [9:0]  level_low;
      logic [7:0]  debounce;
      logic [15:0] close_hold;
      logic [15:0] open_after;
      logic [15:0] report_window;
      logic [15:0] tilt_period;
      logic [14:0] tilt_threshold;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      level_high:     10'd500,
      level_low:      10'd200,
      debounce:       8'd3,
      close_hold:     16'd150,
      open_after:     16'd300,
      report_window:  16'd2000,
      tilt_period:    16'd200,
      tilt_threshold: 15'd7000
   };

   // Event codes on the response channel
   typedef enum logic [2:0] {
      EV_OPEN  = 3'd0,
      EV_CLOSE = 3'd1,
      EV_PAIR  = 3'd2,
      EV_UP    = 3'd3,
      EV_DOWN  = 3'd4,
      EV_LEFT  = 3'd5,
      EV_RIGHT = 3'd6
   } ev_code_type;

   // Last reported tilt direction
   typedef enum logic [2:0] {
      TILT_NONE  = 3'd0,
      TILT_UP    = 3'd1,
      TILT_DOWN  = 3'd2,
      TILT_LEFT  = 3'd3,
      TILT_RIGHT = 3'd4
   } tilt_dir_type;

   // One response word
   typedef struct packed {
      ev_code_type code;
      logic        final_of_run;
   } rsp_word_type;

   // Words written into the response queue by one poll
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type word0;
      rsp_word_type word1;
   } push_type;

endpackage

/* src/ftgd_req_if.sv */
// ----------------------------------------------------------------------------
// ftgd_req_if
// Poll channel: two flex samples, a millisecond timestamp and accelerometer
// X/Y, moved under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ftgd_req_if #(
   parameter int TIME_BITS   = 32,
   parameter int SAMPLE_BITS = 10
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_a;
   logic [SAMPLE_BITS-1:0] sample_b;
   logic [TIME_BITS-1:0]   now_ms;
   logic signed [15:0]     accel_x;
   logic signed [15:0]     accel_y;

   modport source (
      output valid, sample_a, sample_b, now_ms, accel_x, accel_y,
      input  ready
   );

   modport sink (
      input  valid, sample_a, sample_b, now_ms, accel_x, accel_y,
      output ready
   );
endinterface

/* src/ftgd_rsp_if.sv */
// ----------------------------------------------------------------------------
// ftgd_rsp_if
// Event channel: one event code and an end-of-run mark per word, moved
// under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ftgd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_code;
   logic       final_of_run;

   modport source (
      output valid, event_code, final_of_run,
      input  ready
   );

   modport sink (
      input  valid, event_code, final_of_run,
      output ready
   );
endinterface

/* src/ftgd_core.sv */
// ----------------------------------------------------------------------------
// ftgd_core
// Gesture and tilt state of the detector. On each step it runs one poll
// through hysteresis, debounce, gesture tracking, the report window and the
// tilt classifier, and hands zero to two event words to the response queue.
// ----------------------------------------------------------------------------
module ftgd_core #(
   parameter int TIME_BITS   = 32,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ftgd_pkg::cfg_type      cfg,
   input  logic                   step,
   input  logic [SAMPLE_BITS-1:0] sample_a,
   input  logic [SAMPLE_BITS-1:0] sample_b,
   input  logic [TIME_BITS-1:0]   now_ms,
   input  logic signed [15:0]     accel_x,
   input  logic signed [15:0]     accel_y,
   output ftgd_pkg::push_type     push
);
   import ftgd_pkg::*;

   localparam int CMP_W = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;

   // Pending flag positions and debounced patterns
   localparam int FLAG_OPEN  = 0;
   localparam int FLAG_CLOSE = 1;
   localparam int FLAG_START = 2;

   localparam logic [1:0] PATTERN_BOTH_LOW  = 2'd0;
   localparam logic [1:0] PATTERN_A_ONLY    = 2'd2;
   localparam logic [1:0] PATTERN_BOTH_HIGH = 2'd3;

   // State registers
   logic                 level_a_ff, level_a_in;
   logic                 level_b_ff, level_b_in;
   logic                 stable_a_ff, stable_a_in;
   logic                 stable_b_ff, stable_b_in;
   logic [7:0]           count_a_ff, count_a_in;
   logic [7:0]           count_b_ff, count_b_in;
   logic [1:0]           pattern_ff, pattern_in;
   logic                 holding_low_ff, holding_low_in;
   logic [TIME_BITS-1:0] low_start_ff, low_start_in;
   logic [TIME_BITS-1:0] close_seen_ff, close_seen_in;
   logic                 close_latched_ff, close_latched_in;
   logic                 open_latched_ff, open_latched_in;
   logic [TIME_BITS-1:0] window_start_ff, window_start_in;
   logic [2:0]           pending_ff, pending_in;
   logic [TIME_BITS-1:0] tilt_last_ms_ff, tilt_last_ms_in;
   tilt_dir_type         last_tilt_ff, last_tilt_in;

   // Poll datapath
   logic [CMP_W-1:0]     samp_a_x, samp_b_x, thr_high, thr_low;
   logic [7:0]           inc_a, inc_b;
   logic [TIME_BITS-1:0] open_el, win_el, tilt_el;
   logic [TIME_BITS-1:0] hold_start, low_el;
   logic                 hold_latched;
   logic [2:0]           pend;
   logic signed [16:0]   ax_w, ay_w, th_pos, th_neg;
   tilt_dir_type         tilt_dir;
   ev_code_type          tilt_code, gest_code;
   logic                 gest_valid, tilt_valid;

   // Widen samples and thresholds to a common compare width
   assign samp_a_x = CMP_W'(sample_a);
   assign samp_b_x = CMP_W'(sample_b);
   assign thr_high = CMP_W'(cfg.level_high);
   assign thr_low  = CMP_W'(cfg.level_low);

   assign inc_a = count_a_ff + 8'd1;
   assign inc_b = count_b_ff + 8'd1;

   // Elapsed times against stored marks, modulo the timestamp width
   assign open_el = now_ms - close_seen_ff;
   assign win_el  = now_ms - window_start_ff;
   assign tilt_el = now_ms - tilt_last_ms_ff;

   // Signed tilt compares
   assign ax_w   = {accel_x[15], accel_x};
   assign ay_w   = {accel_y[15], accel_y};
   assign th_pos = {2'b00, cfg.tilt_threshold};
   assign th_neg = -th_pos;

   // Classify tilt by priority
   always_comb begin
      tilt_dir  = TILT_NONE;
      tilt_code = EV_UP;
      priority if (ay_w > th_pos) begin
         tilt_dir  = TILT_UP;
         tilt_code = EV_UP;
      end else if (ay_w < th_neg) begin
         tilt_dir  = TILT_DOWN;
         tilt_code = EV_DOWN;
      end else if (ax_w > th_pos) begin
         tilt_dir  = TILT_LEFT;
         tilt_code = EV_LEFT;
      end else if (ax_w < th_neg) begin
         tilt_dir  = TILT_RIGHT;
         tilt_code = EV_RIGHT;
      end else begin
         tilt_dir  = TILT_NONE;
         tilt_code = EV_UP;
      end
   end

   // Run one poll; hold all state when there is no step
   always_comb begin
      level_a_in       = level_a_ff;
      level_b_in       = level_b_ff;
      stable_a_in      = stable_a_ff;
      stable_b_in      = stable_b_ff;
      count_a_in       = count_a_ff;
      count_b_in       = count_b_ff;
      pattern_in       = pattern_ff;
      holding_low_in   = holding_low_ff;
      low_start_in     = low_start_ff;
      close_seen_in    = close_seen_ff;
      close_latched_in = close_latched_ff;
      open_latched_in  = open_latched_ff;
      window_start_in  = window_start_ff;
      pending_in       = pending_ff;
      tilt_last_ms_in  = tilt_last_ms_ff;
      last_tilt_in     = last_tilt_ff;
      pend             = pending_ff;
      hold_start       = low_start_ff;
      hold_latched     = close_latched_ff;
      low_el           = '0;
      gest_valid       = 1'b0;
      gest_code        = EV_OPEN;
      tilt_valid       = 1'b0;

      if (step) begin
         // Hysteresis: the high test wins
         if (samp_a_x > thr_high) begin
            level_a_in = 1'b1;
         end else if (samp_a_x < thr_low) begin
            level_a_in = 1'b0;
         end
         if (samp_b_x > thr_high) begin
            level_b_in = 1'b1;
         end else if (samp_b_x < thr_low) begin
            level_b_in = 1'b0;
         end

         // Debounce channel A
         if (level_a_in != stable_a_ff) begin
            if (inc_a >= cfg.debounce) begin
               stable_a_in = level_a_in;
               count_a_in  = 8'd0;
            end else begin
               count_a_in = inc_a;
            end
         end else begin
            count_a_in = 8'd0;
         end

         // Debounce channel B
         if (level_b_in != stable_b_ff) begin
            if (inc_b >= cfg.debounce) begin
               stable_b_in = level_b_in;
               count_b_in  = 8'd0;
            end else begin
               count_b_in = inc_b;
            end
         end else begin
            count_b_in = 8'd0;
         end

         pattern_in = {stable_a_in, stable_b_in};

         // Start edge
         if (pattern_in == PATTERN_A_ONLY && pattern_ff != PATTERN_A_ONLY) begin
            pend[FLAG_START] = 1'b1;
         end

         // Close: both low held long enough
         if (pattern_in == PATTERN_BOTH_LOW) begin
            hold_start       = holding_low_ff ? low_start_ff : now_ms;
            hold_latched     = holding_low_ff ? close_latched_ff : 1'b0;
            low_el           = now_ms - hold_start;
            holding_low_in   = 1'b1;
            low_start_in     = hold_start;
            close_latched_in = hold_latched;
            if (!hold_latched && low_el >= TIME_BITS'(cfg.close_hold)) begin
               pend[FLAG_CLOSE] = 1'b1;
               close_latched_in = 1'b1;
               close_seen_in    = now_ms;
            end
         end else begin
            holding_low_in   = 1'b0;
            close_latched_in = 1'b0;
         end

         // Open: both high soon after a close
         if (pattern_in == PATTERN_BOTH_HIGH) begin
            if (!open_latched_ff) begin
               if (open_el < TIME_BITS'(cfg.open_after)) begin
                  pend[FLAG_OPEN] = 1'b1;
               end
               open_latched_in = 1'b1;
            end
         end else begin
            open_latched_in = 1'b0;
         end

         // Report window: emit the top pending gesture and restart
         if (win_el >= TIME_BITS'(cfg.report_window)) begin
            priority if (pend[FLAG_OPEN]) begin
               gest_valid = 1'b1;
               gest_code  = EV_OPEN;
            end else if (pend[FLAG_CLOSE]) begin
               gest_valid = 1'b1;
               gest_code  = EV_CLOSE;
            end else if (pend[FLAG_START]) begin
               gest_valid = 1'b1;
               gest_code  = EV_PAIR;
            end else begin
               gest_valid = 1'b0;
               gest_code  = EV_OPEN;
            end
            window_start_in = now_ms;
            pending_in      = 3'd0;
         end else begin
            pending_in = pend;
         end

         // Tilt period: report only a change to a real direction
         if (tilt_el >= TIME_BITS'(cfg.tilt_period)) begin
            tilt_last_ms_in = now_ms;
            if (tilt_dir != TILT_NONE && tilt_dir != last_tilt_ff) begin
               tilt_valid   = 1'b1;
               last_tilt_in = tilt_dir;
            end else if (tilt_dir == TILT_NONE) begin
               last_tilt_in = TILT_NONE;
            end
         end
      end
   end

   // Pack the words of this poll, gesture first
   always_comb begin
      push.count              = {gest_valid & tilt_valid, gest_valid ^ tilt_valid};
      push.word0.code         = gest_valid ? gest_code : tilt_code;
      push.word0.final_of_run = ~(gest_valid & tilt_valid);
      push.word1.code         = tilt_code;
      push.word1.final_of_run = 1'b1;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_a_ff       <= 1'b1;
         level_b_ff       <= 1'b1;
         stable_a_ff      <= 1'b1;
         stable_b_ff      <= 1'b1;
         count_a_ff       <= 8'd0;
         count_b_ff       <= 8'd0;
         pattern_ff       <= PATTERN_BOTH_HIGH;
         holding_low_ff   <= 1'b0;
         low_start_ff     <= '0;
         close_seen_ff    <= '0;
         close_latched_ff <= 1'b0;
         open_latched_ff  <= 1'b0;
         window_start_ff  <= '0;
         pending_ff       <= 3'd0;
         tilt_last_ms_ff  <= '0;
         last_tilt_ff     <= TILT_NONE;
      end else begin
         level_a_ff       <= level_a_in;
         level_b_ff       <= level_b_in;
         stable_a_ff      <= stable_a_in;
         stable_b_ff      <= stable_b_in;
         count_a_ff       <= count_a_in;
         count_b_ff       <= count_b_in;
         pattern_ff       <= pattern_in;
         holding_low_ff   <= holding_low_in;
         low_start_ff     <= low_start_in;
         close_seen_ff    <= close_seen_in;
         close_latched_ff <= close_latched_in;
         open_latched_ff  <= open_latched_in;
         window_start_ff  <= window_start_in;
         pending_ff       <= pending_in;
         tilt_last_ms_ff  <= tilt_last_ms_in;
         last_tilt_ff     <= last_tilt_in;
      end
   end

endmodule

/* src/ftgd_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// ftgd_rsp_fifo
// Four-word response queue. Takes up to two words per cycle from the core,
// gives one word per cycle on the response channel while it is ready, and
// flags room for a full poll (two words).
// ----------------------------------------------------------------------------
module ftgd_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  ftgd_pkg::push_type push,
   output logic               room,
   ftgd_rsp_if.source         rsp_ch
);
   import ftgd_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_word_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] wr_ptr_p1;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   rsp_word_type     head;

   // Drive the response channel from the head word
   assign head                = mem_ff[rd_ptr_ff];
   assign rsp_ch.valid        = (count_ff != '0);
   assign rsp_ch.event_code   = head.code;
   assign rsp_ch.final_of_run = head.final_of_run;
   assign pop                 = rsp_ch.valid & rsp_ch.ready;

   // Room for the largest poll
   assign room = (count_ff <= CNT_W'(DEPTH - 2));

   // Advance pointers and fill level
   assign wr_ptr_p1 = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the words of one poll
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.word0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_p1] <= push.word1;
      end
   end

   // Never push without room for the whole poll
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff <= CNT_W'(DEPTH - 2)))
      else $error("response queue pushed without room");

   // Fill level stays within the queue
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("response queue fill level out of range");

   // Only the last word of a poll carries the end mark
   a_final_pair: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (!push.word0.final_of_run && push.word1.final_of_run))
      else $error("end mark misplaced in a two-word poll");

   a_final_single: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd1) |-> push.word0.final_of_run)
      else $error("end mark missing in a one-word poll");

   // A poll makes at most two words
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("poll produced more than two words");

endmodule

/* src/flex_tilt_gesture_detector_unit.sv */
// ----------------------------------------------------------------------------
// flex_tilt_gesture_detector_unit
// Flex sensor gesture and accelerometer tilt detector, top level.
// ----------------------------------------------------------------------------
// A poll word is taken into an input register, and once the queue has room
// for two words the detector core runs it through hysteresis, debounce,
// gesture tracking, the report window and the tilt classifier, writing zero,
// one or two event words into a four-word response queue. A new poll is
// taken every cycle while the queue has room for two words; the event words
// leave one per cycle while the response channel is ready, so polls that
// each make two events are held back by the single response port. Events
// pass the input register and the response queue. There is no clearing
// pass after reset. Registers may be written on any cycle the block is
// idle; a write takes effect on the next poll.
// ----------------------------------------------------------------------------
module flex_tilt_gesture_detector_unit #(
   parameter int TIME_BITS   = 32,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   ftgd_req_if.sink                          req_ch,
   ftgd_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [ftgd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ftgd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ftgd_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] sample_a_ff, sample_b_ff;
   logic [TIME_BITS-1:0]   now_ms_ff;
   logic signed [15:0]     accel_x_ff, accel_y_ff;
   logic                   room;
   logic                   step;
   logic                   req_take;
   push_type               push;

   // Run the held word when the queue can take a full poll
   assign step          = in_valid_ff & room;
   assign req_ch.ready  = ~in_valid_ff | step;
   assign req_take      = req_ch.valid & req_ch.ready;
   assign in_valid_in   = req_take | (in_valid_ff & ~step);

   // Register file writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_LEVEL_HIGH:     cfg_in.level_high     = csr_wdata[9:0];
            REG_LEVEL_LOW:      cfg_in.level_low      = csr_wdata[9:0];
            REG_DEBOUNCE:       cfg_in.debounce       = csr_wdata[7:0];
            REG_CLOSE_HOLD:     cfg_in.close_hold     = csr_wdata;
            REG_OPEN_AFTER:     cfg_in.open_after     = csr_wdata;
            REG_REPORT_WINDOW:  cfg_in.report_window  = csr_wdata;
            REG_TILT_PERIOD:    cfg_in.tilt_period    = csr_wdata;
            REG_TILT_THRESHOLD: cfg_in.tilt_threshold = csr_wdata[14:0];
         endcase
      end
   end

   // Control and register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         in_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold the accepted poll word
   always_ff @(posedge clock) begin
      if (req_take) begin
         sample_a_ff <= req_ch.sample_a;
         sample_b_ff <= req_ch.sample_b;
         now_ms_ff   <= req_ch.now_ms;
         accel_x_ff  <= req_ch.accel_x;
         accel_y_ff  <= req_ch.accel_y;
      end
   end

   ftgd_core #(
      .TIME_BITS   (TIME_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .step     (step),
      .sample_a (sample_a_ff),
      .sample_b (sample_b_ff),
      .now_ms   (now_ms_ff),
      .accel_x  (accel_x_ff),
      .accel_y  (accel_y_ff),
      .push     (push)
   );

   ftgd_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

endmodule
